// ===== rtl/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// AABB query package
// Shared widths, register indexes and transaction types for the 2D
// axis-aligned box query unit.
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int COORD_BITS     = 24;
    localparam int HALF_BITS      = COORD_BITS - 1;
    localparam int GAP_BITS       = COORD_BITS + 1;
    localparam int TOL_BITS       = 16;
    localparam int CFG_DATA_BITS  = (COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS;
    localparam int CFG_INDEX_BITS = 3;
    // Signed working width of the classifier; holds every sum and difference.
    localparam int EXT_BITS       = CFG_DATA_BITS + 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOX_CENTER_X    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOX_CENTER_Y    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOX_HALF_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOX_HALF_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE       = 3'd4;

    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
        logic        [HALF_BITS-1:0]  query_half_length;
        logic        [HALF_BITS-1:0]  query_half_width;
    } query_t;

    typedef struct packed {
        logic                center_inside;
        logic                center_on_edge;
        logic [GAP_BITS-1:0] gap_distance;
        logic                overlap;
    } result_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] box_center_x;
        logic signed [COORD_BITS-1:0] box_center_y;
        logic        [HALF_BITS-1:0]  box_half_length;
        logic        [HALF_BITS-1:0]  box_half_width;
        logic        [TOL_BITS-1:0]   tolerance;
    } box_cfg_t;

    // Classified query handed from the front end to the distance back end.
    typedef struct packed {
        logic                  hyp;
        logic [GAP_BITS-1:0]   gap_direct;
        logic [COORD_BITS-1:0] gap_a;
        logic [COORD_BITS-1:0] gap_b;
        logic                  center_inside;
        logic                  center_on_edge;
    } front_item_t;

endpackage

// ===== rtl/aabb_front.sv =====
// ----------------------------------------------------------------------------
// AABB front end
// Accepts query transactions, computes the center tests and the per-axis
// gaps, and decides whether the gap needs a square root.
// ----------------------------------------------------------------------------
module aabb_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  aabb_pkg::query_t       in_data,
    input  aabb_pkg::box_cfg_t     box,
    output logic                   push_valid,
    input  logic                   push_ready,
    output aabb_pkg::front_item_t  push_item
);
    import aabb_pkg::*;

    logic                       front_valid_reg;
    front_item_t                front_item_reg;
    front_item_t                item_next;

    logic signed [EXT_BITS-1:0] dx_diff, dy_diff, dx_abs, dy_abs;
    logic signed [EXT_BITS-1:0] hl_e, hw_e, qhl_e, qhw_e, tol_e;
    logic signed [EXT_BITS-1:0] ex, ey, ex_abs, ey_abs;
    logic signed [EXT_BITS-1:0] gx, gy, direct;
    logic                       x_near, y_near;

    always_comb
    begin
        dx_diff = EXT_BITS'(box.box_center_x) - EXT_BITS'(in_data.query_x);
        dy_diff = EXT_BITS'(box.box_center_y) - EXT_BITS'(in_data.query_y);
        dx_abs  = (dx_diff < 0) ? -dx_diff : dx_diff;
        dy_abs  = (dy_diff < 0) ? -dy_diff : dy_diff;

        hl_e    = signed'(EXT_BITS'(box.box_half_length));
        hw_e    = signed'(EXT_BITS'(box.box_half_width));
        qhl_e   = signed'(EXT_BITS'(in_data.query_half_length));
        qhw_e   = signed'(EXT_BITS'(in_data.query_half_width));
        tol_e   = signed'(EXT_BITS'(box.tolerance));

        x_near  = dx_abs < hl_e + tol_e;
        y_near  = dy_abs < hw_e + tol_e;
        ex      = dx_abs - hl_e;
        ey      = dy_abs - hw_e;
        ex_abs  = (ex < 0) ? -ex : ex;
        ey_abs  = (ey < 0) ? -ey : ey;

        gx      = dx_abs - hl_e - qhl_e;
        gy      = dy_abs - hw_e - qhw_e;

        // A gap on only one axis is the answer as it stands.
        if (gx <= 0)
        begin
            direct = (gy > 0) ? gy : '0;
        end
        else
        begin
            direct = gx;
        end

        item_next.hyp            = (gx > 0) && (gy > 0);
        item_next.gap_direct     = direct[GAP_BITS-1:0];
        item_next.gap_a          = gx[COORD_BITS-1:0];
        item_next.gap_b          = gy[COORD_BITS-1:0];
        item_next.center_inside  = x_near && y_near;
        item_next.center_on_edge = ((ex_abs < tol_e) && y_near) ||
                                   (x_near && (ey_abs < tol_e));
    end

    assign in_ready   = !front_valid_reg || push_ready;
    assign push_valid = front_valid_reg;
    assign push_item  = front_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            front_item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/aabb_fifo.sv =====
// ----------------------------------------------------------------------------
// AABB queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module aabb_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  aabb_pkg::front_item_t push_item,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output aabb_pkg::front_item_t pop_item
);
    import aabb_pkg::*;

    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    front_item_t           entry_reg [0:DEPTH-1];
    logic [IDX_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  push, pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/aabb_back.sv =====
// ----------------------------------------------------------------------------
// AABB back end
// Squares the axis gaps, takes a pipelined floor square root one result
// bit per stage, and forms the final result transaction.
// ----------------------------------------------------------------------------
module aabb_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  aabb_pkg::front_item_t           pop_item,
    input  logic [aabb_pkg::TOL_BITS-1:0]   tolerance,
    output logic                            out_valid,
    input  logic                            out_ready,
    output aabb_pkg::result_t               out_data
);
    import aabb_pkg::*;

    localparam int ROOT_BITS = GAP_BITS;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int CMP_BITS  = (GAP_BITS > TOL_BITS) ? GAP_BITS : TOL_BITS;

    typedef struct packed {
        logic                hyp;
        logic [GAP_BITS-1:0] gap_direct;
        logic                center_inside;
        logic                center_on_edge;
    } side_t;

    logic                    adv;

    // Square stage
    logic                    m_valid_reg;
    side_t                   m_side_reg;
    logic [2*COORD_BITS-1:0] m_sqa_reg, m_sqb_reg;

    // Sum stage, radicand for the root
    logic                    s0_valid_reg;
    side_t                   s0_side_reg;
    logic [RAD_BITS-1:0]     s0_rad_reg;

    // Root stages
    logic [ROOT_BITS:1]      sq_valid_reg;
    side_t                   side_reg  [1:ROOT_BITS];
    logic [RAD_BITS-1:0]     rad_reg   [1:ROOT_BITS];
    logic [RAD_BITS-1:0]     rad_next  [1:ROOT_BITS];
    logic [RAD_BITS-1:0]     prev_rad  [1:ROOT_BITS];
    logic [REM_BITS-1:0]     rem_reg   [1:ROOT_BITS];
    logic [REM_BITS-1:0]     rem_next  [1:ROOT_BITS];
    logic [REM_BITS-1:0]     prev_rem  [1:ROOT_BITS];
    logic [ROOT_BITS-1:0]    root_reg  [1:ROOT_BITS];
    logic [ROOT_BITS-1:0]    root_next [1:ROOT_BITS];
    logic [ROOT_BITS-1:0]    prev_root [1:ROOT_BITS];

    logic                    out_valid_reg;
    result_t                 out_data_reg;
    logic [GAP_BITS-1:0]     gap_sel;

    // The whole pipeline moves together whenever the output register frees up.
    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    for (genvar s = 1; s <= ROOT_BITS; s++)
    begin : g_root
        logic [REM_BITS-1:0] shifted;
        logic [REM_BITS-1:0] trial;
        logic                fits;

        if (s == 1)
        begin : g_first
            assign prev_rad[s]  = s0_rad_reg;
            assign prev_rem[s]  = '0;
            assign prev_root[s] = '0;
        end
        else
        begin : g_next
            assign prev_rad[s]  = rad_reg[s-1];
            assign prev_rem[s]  = rem_reg[s-1];
            assign prev_root[s] = root_reg[s-1];
        end

        assign shifted      = {prev_rem[s][REM_BITS-3:0], prev_rad[s][RAD_BITS-1 -: 2]};
        assign trial        = {prev_root[s], 2'b01};
        assign fits         = shifted >= trial;
        assign rem_next[s]  = fits ? shifted - trial : shifted;
        assign root_next[s] = {prev_root[s][ROOT_BITS-2:0], fits};
        assign rad_next[s]  = {prev_rad[s][RAD_BITS-3:0], 2'b00};
    end

    assign gap_sel = side_reg[ROOT_BITS].hyp ? root_reg[ROOT_BITS]
                                             : side_reg[ROOT_BITS].gap_direct;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            s0_valid_reg  <= 1'b0;
            sq_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg   <= pop_valid;
            s0_valid_reg  <= m_valid_reg;
            sq_valid_reg  <= {sq_valid_reg[ROOT_BITS-1:1], s0_valid_reg};
            out_valid_reg <= sq_valid_reg[ROOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_side_reg.hyp            <= pop_item.hyp;
            m_side_reg.gap_direct     <= pop_item.gap_direct;
            m_side_reg.center_inside  <= pop_item.center_inside;
            m_side_reg.center_on_edge <= pop_item.center_on_edge;
            m_sqa_reg                 <= pop_item.gap_a * pop_item.gap_a;
            m_sqb_reg                 <= pop_item.gap_b * pop_item.gap_b;

            s0_side_reg <= m_side_reg;
            s0_rad_reg  <= RAD_BITS'(m_sqa_reg) + RAD_BITS'(m_sqb_reg);

            side_reg[1] <= s0_side_reg;
            for (int i = 2; i <= ROOT_BITS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 1; i <= ROOT_BITS; i++)
            begin
                rad_reg[i]  <= rad_next[i];
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
            end

            out_data_reg.center_inside  <= side_reg[ROOT_BITS].center_inside;
            out_data_reg.center_on_edge <= side_reg[ROOT_BITS].center_on_edge;
            out_data_reg.gap_distance   <= gap_sel;
            out_data_reg.overlap        <= CMP_BITS'(gap_sel) < CMP_BITS'(tolerance);
        end
    end

endmodule

// ===== rtl/aabb_2d_query_unit.sv =====
// ----------------------------------------------------------------------------
// AABB 2D query unit
// Tests query boxes against one configured axis-aligned box.
// ----------------------------------------------------------------------------
// Usage:
// Program the box through the write port (cfg_write_en, cfg_index,
// cfg_data) while no transaction is in flight; unknown indexes are ignored.
// Query transactions enter on in_valid/in_ready and results leave on
// out_valid/out_ready, one result per query, in order.
// Throughput is one transaction per cycle while out_ready stays high. From the
// accepting edge to out_valid a query passes one classifier register, one
// queue slot, a squaring stage, a sum stage, one stage per root bit of the
// floor square root and the output register.
// When out_valid is high and out_ready is low the back end holds; the queue between front and
// back keeps taking transactions until it fills, then in_ready drops.
// Reset empties the pipeline and queue, returns the box to zero size at
// the origin and sets the tolerance to one LSB.
// ----------------------------------------------------------------------------
module aabb_2d_query_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [aabb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [aabb_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  aabb_pkg::query_t                      in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output aabb_pkg::result_t                     out_data
);
    import aabb_pkg::*;

    box_cfg_t    box_reg;
    logic        push_valid, push_ready;
    front_item_t push_item;
    logic        pop_valid, pop_ready;
    front_item_t pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.box_center_x    <= '0;
            box_reg.box_center_y    <= '0;
            box_reg.box_half_length <= '0;
            box_reg.box_half_width  <= '0;
            box_reg.tolerance       <= TOL_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_BOX_CENTER_X:    box_reg.box_center_x    <= cfg_data[COORD_BITS-1:0];
                CFG_BOX_CENTER_Y:    box_reg.box_center_y    <= cfg_data[COORD_BITS-1:0];
                CFG_BOX_HALF_LENGTH: box_reg.box_half_length <= cfg_data[HALF_BITS-1:0];
                CFG_BOX_HALF_WIDTH:  box_reg.box_half_width  <= cfg_data[HALF_BITS-1:0];
                CFG_TOLERANCE:       box_reg.tolerance       <= cfg_data[TOL_BITS-1:0];
                default:             ;
            endcase
        end
    end

    aabb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .box        (box_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    aabb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    aabb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .tolerance (box_reg.tolerance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/aabb_checker.sv =====
// ----------------------------------------------------------------------------
// AABB port checker
// Watches the top-level ports of the query unit and checks result
// consistency and transaction accounting.
// ----------------------------------------------------------------------------
module aabb_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [aabb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [aabb_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  aabb_pkg::result_t                     out_data
);
    import aabb_pkg::*;

    localparam int CMP_BITS = (GAP_BITS > TOL_BITS) ? GAP_BITS : TOL_BITS;

    logic [TOL_BITS-1:0] tol_shadow_reg;
    logic [15:0]         pending_reg;
    logic                in_take, out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_shadow_reg <= TOL_RESET;
            pending_reg    <= '0;
        end
        else
        begin
            if (cfg_write_en && (cfg_index == CFG_TOLERANCE))
            begin
                tol_shadow_reg <= cfg_data[TOL_BITS-1:0];
            end
            if (in_take && !out_take)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (out_take && !in_take)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
        end
    end

    // A stalled result must not change under the receiver.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // Every result must belong to an accepted query transaction.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result without an outstanding query");

    // A center on the boundary band is always inside the grown box.
    a_edge_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.center_on_edge |-> out_data.center_inside)
        else $error("edge flag set without inside flag");

    // The overlap flag follows the gap and the programmed tolerance.
    a_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.overlap ==
            (CMP_BITS'(out_data.gap_distance) < CMP_BITS'(tol_shadow_reg)))
        else $error("overlap flag disagrees with gap and tolerance");

endmodule

bind aabb_2d_query_unit aabb_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
);
